// ===== rtl/edfbdf_pkg.sv =====
package edfbdf_pkg;

    localparam int FRACTION_BITS = 16;

    localparam int BYTE_W  = 8;
    localparam int RAW_W   = 24;
    localparam int DIFF_W  = RAW_W + 1;
    localparam int GAIN_W  = 32;
    localparam int PROD_W  = DIFF_W + GAIN_W;
    localparam int VALUE_W = 48;
    localparam int SUM_W   = PROD_W + 1;
    localparam int WORDS_W = 20;
    localparam int RECS_W  = 24;

    localparam int QUEUE_DEPTH = 4;

    localparam int APB_DATA_W = 64;
    localparam int APB_ADDR_W = 6;
    localparam int REG_IDX_W  = 3;

    localparam logic [VALUE_W-1:0] SAT_HIGH = {1'b0, {(VALUE_W-1){1'b1}}};
    localparam logic [VALUE_W-1:0] SAT_LOW  = {1'b1, {(VALUE_W-1){1'b0}}};

    localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(64'd1 << FRACTION_BITS);

    // register map, one 64-bit slot per register
    localparam logic [REG_IDX_W-1:0] REG_WIDE_MODE    = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_RECORD_WORDS = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_SKIP_WORDS   = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_TAKE_WORDS   = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_RECORD_COUNT = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_DIGITAL_MIN  = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_GAIN         = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_PHYSICAL_MIN = 3'd7;

    typedef struct packed {
        logic               wide_mode;
        logic [WORDS_W-1:0] record_words;
        logic [WORDS_W-1:0] skip_words;
        logic [WORDS_W-1:0] take_words;
        logic [RECS_W-1:0]  record_count;
    } t_front_cfg;

    typedef struct packed {
        logic [RAW_W-1:0]   digital_min;
        logic [GAIN_W-1:0]  gain;
        logic [VALUE_W-1:0] physical_min;
    } t_back_cfg;

    // one decoded word of the chosen channel, waiting for scaling
    typedef struct packed {
        logic [RAW_W-1:0] raw;
        logic             last;
    } t_work;

endpackage

// ===== rtl/edfbdf_front.sv =====
module edfbdf_front
    import edfbdf_pkg::*;
#(
    parameter int MAX_SAMPLES = 1048576
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_front_cfg        i_cfg,
    input  logic              i_valid,
    input  logic [BYTE_W-1:0] i_data_byte,
    input  logic              i_full,
    output logic              o_stall,
    output logic              o_push,
    output t_work             o_work
);

    localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_SAMPLES);

    logic [1:0]         r_phase, n_phase;
    logic [15:0]        r_low, n_low;
    logic [WORDS_W-1:0] r_pos, n_pos;
    logic [RECS_W-1:0]  r_rec, n_rec;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic               r_done, n_done;

    logic               accept;
    logic               active;
    logic               hold_byte;
    logic               word_done;
    logic [RAW_W-1:0]   raw;
    logic               end_rec;
    logic               last_rec;
    logic [WORDS_W-1:0] offset;
    logic               in_window;
    logic               final_in_rec;
    logic [CNT_W-1:0]   cnt_inc;
    logic               is_last;

    assign o_stall = i_full;
    assign accept  = i_valid && !i_full;

    always_comb begin
        active    = !r_done && (r_rec < i_cfg.record_count);
        hold_byte = i_cfg.wide_mode ? (r_phase < 2'd2) : (r_phase < 2'd1);
        word_done = accept && active && !hold_byte;

        // a narrow word built after a mode change uses only the first held byte
        raw = i_cfg.wide_mode ? {i_data_byte, r_low}
                              : {{8{i_data_byte[7]}}, i_data_byte, r_low[7:0]};

        end_rec  = ({1'b0, r_pos} + 21'd1) >= {1'b0, i_cfg.record_words};
        last_rec = ({1'b0, r_rec} + 25'd1) >= {1'b0, i_cfg.record_count};

        offset       = r_pos - i_cfg.skip_words;
        in_window    = (r_pos >= i_cfg.skip_words) && (offset < i_cfg.take_words);
        final_in_rec = (({1'b0, offset} + 21'd1) >= {1'b0, i_cfg.take_words}) || end_rec;

        cnt_inc = r_cnt + CNT_W'(1);
        is_last = (cnt_inc >= CNT_MAX) || (last_rec && final_in_rec);

        n_phase = r_phase;
        n_low   = r_low;
        n_pos   = r_pos;
        n_rec   = r_rec;
        n_cnt   = r_cnt;
        n_done  = r_done;

        if (accept && active) begin
            if (hold_byte) begin
                n_low   = r_low | (r_phase[0] ? {i_data_byte, 8'h00} : {8'h00, i_data_byte});
                n_phase = r_phase + 2'd1;
            end else begin
                n_phase = 2'd0;
                n_low   = 16'h0000;
                if (in_window) begin
                    n_cnt = cnt_inc;
                    if (is_last) begin
                        n_done = 1'b1;
                    end
                end
                if (end_rec) begin
                    n_pos = '0;
                    n_rec = r_rec + RECS_W'(1);
                    if (last_rec) begin
                        n_done = 1'b1;
                    end
                end else begin
                    n_pos = r_pos + WORDS_W'(1);
                end
            end
        end

        o_push      = word_done && in_window;
        o_work.raw  = raw;
        o_work.last = is_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= 2'd0;
            r_low   <= 16'h0000;
            r_pos   <= '0;
            r_rec   <= '0;
            r_cnt   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_low   <= n_low;
            r_pos   <= n_pos;
            r_rec   <= n_rec;
            r_cnt   <= n_cnt;
            r_done  <= n_done;
        end
    end

    a_done_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> r_done)
        else $error("decode restarted after finishing");

    a_push_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |=> (r_cnt == CNT_W'($past(r_cnt) + CNT_W'(1))))
        else $error("sample count out of step with pushed samples");

endmodule

// ===== rtl/edfbdf_queue.sv =====
module edfbdf_queue
    import edfbdf_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_work i_work,
    input  logic  i_pop,
    output logic  o_full,
    output logic  o_valid,
    output t_work o_work
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_work              r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]   r_wr, n_wr;
    logic [PTR_W-1:0]   r_rd, n_rd;
    logic [CNT_W-1:0]   r_count, n_count;

    always_comb begin
        n_wr    = i_push ? r_wr + PTR_W'(1) : r_wr;
        n_rd    = i_pop ? r_rd + PTR_W'(1) : r_rd;
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - CNT_W'(1);
        end
        o_full  = (r_count == CNT_W'(QUEUE_DEPTH));
        o_valid = (r_count != '0);
        o_work  = r_mem[r_rd];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_work;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("pop from empty queue");

endmodule

// ===== rtl/edfbdf_back.sv =====
module edfbdf_back
    import edfbdf_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_back_cfg          i_cfg,
    input  logic               i_q_valid,
    input  t_work              i_q_work,
    output logic               o_pop,
    input  logic               i_stall,
    output logic               o_valid,
    output logic [VALUE_W-1:0] o_sample_value,
    output logic               o_clipped,
    output logic               o_last
);

    logic                     r_v1;
    logic signed [PROD_W-1:0] r_prod;
    logic                     r_last1;

    logic                     r_ovalid;
    logic [VALUE_W-1:0]       r_value;
    logic                     r_clip;
    logic                     r_last;

    logic                     out_ready;
    logic                     s1_ready;
    logic signed [DIFF_W-1:0] diff;
    logic signed [PROD_W-1:0] prod;
    logic [SUM_W-1:0]         sum;
    logic                     in_range;
    logic [VALUE_W-1:0]       sat_value;
    logic                     sat_clip;

    always_comb begin
        out_ready = !r_ovalid || !i_stall;
        s1_ready  = !r_v1 || out_ready;
        o_pop     = i_q_valid && s1_ready;

        diff = $signed({i_q_work.raw[RAW_W-1], i_q_work.raw})
             - $signed({i_cfg.digital_min[RAW_W-1], i_cfg.digital_min});
        prod = diff * $signed(i_cfg.gain);

        sum = {r_prod[PROD_W-1], r_prod}
            + {{(SUM_W-VALUE_W){i_cfg.physical_min[VALUE_W-1]}}, i_cfg.physical_min};

        // fits in 48 bits when all bits above the sign bit agree with it
        in_range = (sum[SUM_W-1:VALUE_W-1] == '0) || (sum[SUM_W-1:VALUE_W-1] == '1);
        if (in_range) begin
            sat_value = sum[VALUE_W-1:0];
            sat_clip  = 1'b0;
        end else begin
            sat_value = sum[SUM_W-1] ? SAT_LOW : SAT_HIGH;
            sat_clip  = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1     <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (s1_ready) begin
                r_v1 <= i_q_valid;
            end
            if (out_ready) begin
                r_ovalid <= r_v1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_prod  <= prod;
            r_last1 <= i_q_work.last;
        end
        if (out_ready && r_v1) begin
            r_value <= sat_value;
            r_clip  <= sat_clip;
            r_last  <= r_last1;
        end
    end

    assign o_valid        = r_ovalid;
    assign o_sample_value = r_value;
    assign o_clipped      = r_clip;
    assign o_last         = r_last;

    a_clip_at_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_clip) |-> (r_value == SAT_HIGH || r_value == SAT_LOW))
        else $error("clipped sample not at a saturation bound");

    a_stage_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 && !out_ready) |=> (r_v1 && $stable(r_prod) && $stable(r_last1)))
        else $error("product stage lost or changed a held transaction");

endmodule

// ===== rtl/edf_bdf_channel_sample_decoder_top.sv =====
// Channel   Direction  Handshake          Payload
// input     in         i_valid / o_stall  i_data_byte[7:0]
// output    out        o_valid / i_stall  o_sample_value[47:0], o_clipped, o_last
// config    in         APB psel/penable   paddr[5:0] (8-byte slots), pwdata/prdata[63:0]
//
// One data byte per cycle is accepted while o_stall is low.
// A sample passes the queue write, the multiply stage and the add/saturate output
// register on its way from its final byte to the output.
// o_stall rises only when the four-entry queue in front of the multiplier is full.
// Synchronous active-low reset clears the decode position and counters and sets the config registers to defaults.
module edf_bdf_channel_sample_decoder_top
    import edfbdf_pkg::*;
#(
    parameter int MAX_SAMPLES = 1048576
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [BYTE_W-1:0]     i_data_byte,

    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [VALUE_W-1:0]    o_sample_value,
    output logic                  o_clipped,
    output logic                  o_last,

    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    logic               r_wide_mode;
    logic [WORDS_W-1:0] r_record_words;
    logic [WORDS_W-1:0] r_skip_words;
    logic [WORDS_W-1:0] r_take_words;
    logic [RECS_W-1:0]  r_record_count;
    logic [RAW_W-1:0]   r_digital_min;
    logic [GAIN_W-1:0]  r_gain;
    logic [VALUE_W-1:0] r_physical_min;

    logic                 reg_write;
    logic [REG_IDX_W-1:0] reg_idx;
    t_front_cfg           front_cfg;
    t_back_cfg            back_cfg;

    logic  push;
    t_work push_work;
    logic  q_full;
    logic  q_valid;
    t_work q_work;
    logic  pop;

    assign pready    = 1'b1;
    assign reg_idx   = paddr[APB_ADDR_W-1:APB_ADDR_W-REG_IDX_W];
    assign reg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wide_mode    <= 1'b0;
            r_record_words <= WORDS_W'(1);
            r_skip_words   <= '0;
            r_take_words   <= WORDS_W'(1);
            r_record_count <= RECS_W'(1);
            r_digital_min  <= '0;
            r_gain         <= GAIN_RESET;
            r_physical_min <= '0;
        end else if (reg_write) begin
            unique case (reg_idx)
                REG_WIDE_MODE:    r_wide_mode    <= pwdata[0];
                REG_RECORD_WORDS: r_record_words <= pwdata[WORDS_W-1:0];
                REG_SKIP_WORDS:   r_skip_words   <= pwdata[WORDS_W-1:0];
                REG_TAKE_WORDS:   r_take_words   <= pwdata[WORDS_W-1:0];
                REG_RECORD_COUNT: r_record_count <= pwdata[RECS_W-1:0];
                REG_DIGITAL_MIN:  r_digital_min  <= pwdata[RAW_W-1:0];
                REG_GAIN:         r_gain         <= pwdata[GAIN_W-1:0];
                REG_PHYSICAL_MIN: r_physical_min <= pwdata[VALUE_W-1:0];
                default:          r_wide_mode    <= r_wide_mode;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_WIDE_MODE:    prdata = APB_DATA_W'(r_wide_mode);
            REG_RECORD_WORDS: prdata = APB_DATA_W'(r_record_words);
            REG_SKIP_WORDS:   prdata = APB_DATA_W'(r_skip_words);
            REG_TAKE_WORDS:   prdata = APB_DATA_W'(r_take_words);
            REG_RECORD_COUNT: prdata = APB_DATA_W'(r_record_count);
            REG_DIGITAL_MIN:  prdata = APB_DATA_W'(r_digital_min);
            REG_GAIN:         prdata = APB_DATA_W'(r_gain);
            REG_PHYSICAL_MIN: prdata = APB_DATA_W'(r_physical_min);
            default:          prdata = '0;
        endcase
    end

    always_comb begin
        front_cfg.wide_mode    = r_wide_mode;
        front_cfg.record_words = r_record_words;
        front_cfg.skip_words   = r_skip_words;
        front_cfg.take_words   = r_take_words;
        front_cfg.record_count = r_record_count;
        back_cfg.digital_min   = r_digital_min;
        back_cfg.gain          = r_gain;
        back_cfg.physical_min  = r_physical_min;
    end

    edfbdf_front #(
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (front_cfg),
        .i_valid     (i_valid),
        .i_data_byte (i_data_byte),
        .i_full      (q_full),
        .o_stall     (o_stall),
        .o_push      (push),
        .o_work      (push_work)
    );

    edfbdf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_work  (push_work),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_work  (q_work)
    );

    edfbdf_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (back_cfg),
        .i_q_valid      (q_valid),
        .i_q_work       (q_work),
        .o_pop          (pop),
        .i_stall        (i_stall),
        .o_valid        (o_valid),
        .o_sample_value (o_sample_value),
        .o_clipped      (o_clipped),
        .o_last         (o_last)
    );

endmodule

// ===== tb/edf_bdf_channel_sample_decoder_top_tb.sv =====
`timescale 1ns / 1ps

module edf_bdf_channel_sample_decoder_top_tb;
    import edfbdf_pkg::*;

    localparam int     DUT_MAX_SAMPLES = 1048576;
    localparam int     WATCHDOG_LIMIT  = 4000;
    localparam int     PIPE_SETTLE     = 12;
    localparam int     RANDOM_BYTES    = 1750;
    localparam int     MAX_REPORTS     = 40;
    localparam longint VALUE_MAX       = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint VALUE_MIN       = -VALUE_MAX - 1;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               clipped;
        logic               last;
    } t_scaled_sample;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_valid;
    logic                  o_stall;
    logic [BYTE_W-1:0]     i_data_byte;
    logic                  o_valid;
    logic                  i_stall;
    logic [VALUE_W-1:0]    o_sample_value;
    logic                  o_clipped;
    logic                  o_last;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // register shadow
    logic               m_wide       = 1'b0;
    logic [19:0]        m_rec_words  = 20'd1;
    logic [19:0]        m_skip       = 20'd0;
    logic [19:0]        m_take       = 20'd1;
    logic [23:0]        m_rec_count  = 24'd1;
    logic signed [23:0] m_dmin       = '0;
    logic signed [31:0] m_gain       = GAIN_RESET;
    logic signed [47:0] m_pmin       = '0;

    // decoder position
    logic [1:0]  phase_q     = '0;
    logic [15:0] low_bytes_q = '0;
    logic [19:0] word_pos_q  = '0;
    logic [23:0] rec_idx_q   = '0;
    int unsigned emitted_q   = 0;
    bit          done_q      = 1'b0;

    t_scaled_sample pending_samples[$];

    int unsigned send_idle_pct   = 0;
    int unsigned stall_pct       = 0;
    int unsigned error_count     = 0;
    int unsigned bytes_sent      = 0;
    int unsigned bytes_decoded   = 0;
    int unsigned samples_checked = 0;
    int unsigned clipped_seen    = 0;
    int unsigned last_seen       = 0;
    int unsigned config_writes   = 0;
    int unsigned random_phases   = 0;

    edf_bdf_channel_sample_decoder_top #(
        .MAX_SAMPLES(DUT_MAX_SAMPLES)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_data_byte    (i_data_byte),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_sample_value (o_sample_value),
        .o_clipped      (o_clipped),
        .o_last         (o_last),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            i_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // Advance the decode position by one byte; queue the scaled sample if one results.
    // Returns 0 when the byte is dropped.
    function automatic bit decode_byte(input logic [7:0] b);
        longint      raw;
        longint      v;
        int unsigned p;
        bit          end_rec;
        bit          last_rec;
        bit          final_in_rec;
        bit          clip;
        bit          is_last;
        t_scaled_sample s;

        if (done_q || rec_idx_q >= m_rec_count)
            return 1'b0;

        if (phase_q < (m_wide ? 2'd2 : 2'd1)) begin
            low_bytes_q = low_bytes_q | (16'(b) << (8 * phase_q));
            phase_q++;
            return 1'b1;
        end

        if (m_wide) begin
            raw = longint'($signed({b, low_bytes_q}));
        end else begin
            raw = longint'($signed({b, low_bytes_q[7:0]}));
        end
        phase_q     = '0;
        low_bytes_q = '0;

        p        = 32'(word_pos_q);
        end_rec  = (p + 1 >= m_rec_words);
        last_rec = (rec_idx_q + 1 >= m_rec_count);

        if (p >= m_skip && p - m_skip < m_take) begin
            v = (raw - longint'(m_dmin)) * longint'(m_gain) + longint'(m_pmin);
            clip = 1'b0;
            final_in_rec = (p - m_skip + 1 >= m_take) || end_rec;
            if (v > VALUE_MAX) begin
                v    = VALUE_MAX;
                clip = 1'b1;
            end else if (v < VALUE_MIN) begin
                v    = VALUE_MIN;
                clip = 1'b1;
            end
            emitted_q++;
            is_last   = (emitted_q >= DUT_MAX_SAMPLES) || (last_rec && final_in_rec);
            s.value   = v[47:0];
            s.clipped = clip;
            s.last    = is_last;
            pending_samples.insert(pending_samples.size(), s);
            if (is_last)
                done_q = 1'b1;
        end

        if (end_rec) begin
            word_pos_q = '0;
            rec_idx_q++;
            if (last_rec)
                done_q = 1'b1;
        end else begin
            word_pos_q = 20'(p + 1);
        end
        return 1'b1;
    endfunction

    function automatic logic [63:0] reg_mask(input logic [REG_IDX_W-1:0] idx);
        case (idx)
            REG_WIDE_MODE:    return 64'h1;
            REG_RECORD_WORDS: return 64'hF_FFFF;
            REG_SKIP_WORDS:   return 64'hF_FFFF;
            REG_TAKE_WORDS:   return 64'hF_FFFF;
            REG_RECORD_COUNT: return 64'hFF_FFFF;
            REG_DIGITAL_MIN:  return 64'hFF_FFFF;
            REG_GAIN:         return 64'hFFFF_FFFF;
            REG_PHYSICAL_MIN: return 64'hFFFF_FFFF_FFFF;
            default:          return 64'h0;
        endcase
    endfunction

    task automatic send_byte(input logic [7:0] b);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid     <= 1'b1;
        i_data_byte <= b;
        do @(posedge i_clk); while (o_stall);
        bytes_sent++;
        if (decode_byte(b))
            bytes_decoded++;
    endtask

    task automatic send_word(input logic [23:0] w);
        send_byte(w[7:0]);
        send_byte(w[15:8]);
        if (m_wide)
            send_byte(w[23:16]);
    endtask

    // Drop valid, drain every outstanding sample, then let the pipeline go quiet.
    task automatic settle();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_samples.size() != 0)
            @(posedge i_clk);
        repeat (PIPE_SETTLE) @(posedge i_clk);
    endtask

    task automatic check_reg(input logic [REG_IDX_W-1:0] idx, input logic [63:0] want);
        logic [63:0] got;
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 3'b000};
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        got = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (((got ^ want) & reg_mask(idx)) != 0) begin
            error_count++;
            if (error_count <= MAX_REPORTS)
                $display("%0t: register %0d readback expected %h got %h", $time, idx,
                         want & reg_mask(idx), got & reg_mask(idx));
        end
    endtask

    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [63:0] data);
        case (idx)
            REG_WIDE_MODE:    m_wide      = data[0];
            REG_RECORD_WORDS: m_rec_words = data[19:0];
            REG_SKIP_WORDS:   m_skip      = data[19:0];
            REG_TAKE_WORDS:   m_take      = data[19:0];
            REG_RECORD_COUNT: m_rec_count = data[23:0];
            REG_DIGITAL_MIN:  m_dmin      = data[23:0];
            REG_GAIN:         m_gain      = data[31:0];
            REG_PHYSICAL_MIN: m_pmin      = data[47:0];
            default: ;
        endcase
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        config_writes++;
        check_reg(idx, data);
    endtask

    always @(posedge i_clk) begin : sample_check
        t_scaled_sample want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_samples.size() == 0) begin
                error_count++;
                if (error_count <= MAX_REPORTS)
                    $display("%0t: unexpected sample: expected none, got value %h clipped %b last %b",
                             $time, o_sample_value, o_clipped, o_last);
            end else begin
                want = pending_samples.pop_front();
                samples_checked++;
                clipped_seen += want.clipped;
                last_seen    += want.last;
                if (o_sample_value !== want.value) begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                        $display("%0t: sample_value expected %h got %h",
                                 $time, want.value, o_sample_value);
                end
                if (o_clipped !== want.clipped) begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                        $display("%0t: clipped expected %b got %b",
                                 $time, want.clipped, o_clipped);
                end
                if (o_last !== want.last) begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                        $display("%0t: last expected %b got %b", $time, want.last, o_last);
                end
            end
        end
    end

    initial begin : watchdog
        int unsigned quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && !o_stall) || (o_valid && !i_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("%0t: no transaction for %0d cycles, %0d samples outstanding",
                 $time, WATCHDOG_LIMIT, pending_samples.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    task automatic test_register_reset();
        check_reg(REG_WIDE_MODE, 64'd0);
        check_reg(REG_RECORD_WORDS, 64'd1);
        check_reg(REG_SKIP_WORDS, 64'd0);
        check_reg(REG_TAKE_WORDS, 64'd1);
        check_reg(REG_RECORD_COUNT, 64'd1);
        check_reg(REG_DIGITAL_MIN, 64'd0);
        check_reg(REG_GAIN, 64'(GAIN_RESET));
        check_reg(REG_PHYSICAL_MIN, 64'd0);
    endtask

    task automatic test_edf_word_extremes();
        // raise the record count so the decode stays open
        write_reg(REG_RECORD_COUNT, 64'hFF_FFFF);
        send_word(24'h00_7FFF);
        send_word(24'h00_8000);
    endtask

    task automatic test_saturation();
        settle();
        write_reg(REG_WIDE_MODE, 64'd1);
        write_reg(REG_DIGITAL_MIN, 64'h80_0000);
        write_reg(REG_GAIN, 64'h7FFF_FFFF);
        write_reg(REG_PHYSICAL_MIN, 64'h7FFF_FFFF_FFFF);
        send_word(24'h7F_FFFF);
        settle();
        write_reg(REG_DIGITAL_MIN, 64'h7F_FFFF);
        write_reg(REG_GAIN, 64'h8000_0000);
        write_reg(REG_PHYSICAL_MIN, 64'h8000_0000_0000);
        send_word(24'h7F_FFFF);
        settle();
        write_reg(REG_GAIN, 64'h7FFF_FFFF);
        send_word(24'h80_0000);
    endtask

    task automatic test_width_switch();
        // two bytes held in wide mode, then finish the word as a narrow one
        send_byte(8'hA5);
        send_byte(8'h3C);
        settle();
        write_reg(REG_WIDE_MODE, 64'd0);
        send_byte(8'h81);
    endtask

    task automatic test_zero_record_count();
        settle();
        write_reg(REG_RECORD_COUNT, 64'd0);
        send_byte(8'h12);
        send_byte(8'hED);
        settle();
        write_reg(REG_RECORD_COUNT, 64'hFF_FFFF);
    endtask

    task automatic test_zero_take();
        settle();
        write_reg(REG_TAKE_WORDS, 64'd0);
        send_word(24'h00_1234);
        settle();
        write_reg(REG_TAKE_WORDS, 64'd1);
    endtask

    task automatic test_zero_record_words();
        settle();
        write_reg(REG_RECORD_WORDS, 64'd0);
        send_word(24'h00_C001);
    endtask

    task automatic test_window_past_record_end();
        settle();
        write_reg(REG_RECORD_WORDS, 64'd2);
        write_reg(REG_SKIP_WORDS, 64'd1);
        write_reg(REG_TAKE_WORDS, 64'd4);
        send_word(24'h00_0102);
        send_word(24'h00_FE80);
    endtask

    task automatic test_random_streams();
        int unsigned target;
        int unsigned shape;
        int unsigned length;
        logic [19:0] words;
        logic [19:0] skip;
        logic [19:0] take;
        logic [63:0] count;
        logic [31:0] r;
        logic [7:0]  b;

        target = bytes_sent + RANDOM_BYTES;
        while (bytes_sent < target) begin
            settle();
            case (random_phases % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 60; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 60; end
                default: begin send_idle_pct = 21; stall_pct = 21; end
            endcase

            shape = $urandom_range(9);
            words = 20'($urandom_range(8, 1));
            skip  = 20'($urandom_range(words));
            take  = 20'($urandom_range(4));
            if (shape == 0) begin
                words = '0;
            end else if (shape == 1) begin
                words = 20'hF_FFFF;
                take  = 20'hF_FFFF;
            end else if (shape == 2) begin
                skip = 20'hF_FFFF;
            end

            // now and then park the decode so the bytes are dropped
            if ($urandom_range(7) == 0)
                count = 64'($urandom_range(rec_idx_q));
            else
                count = 64'hFF_FFFF;

            write_reg(REG_WIDE_MODE, 64'($urandom_range(1)));
            write_reg(REG_RECORD_WORDS, 64'(words));
            write_reg(REG_SKIP_WORDS, 64'(skip));
            write_reg(REG_TAKE_WORDS, 64'(take));
            write_reg(REG_RECORD_COUNT, count);
            write_reg(REG_DIGITAL_MIN, 64'($urandom));
            if ($urandom_range(3) == 0) begin
                write_reg(REG_GAIN, 64'($urandom));
                write_reg(REG_PHYSICAL_MIN, {$urandom, $urandom});
            end else begin
                r = $urandom;
                write_reg(REG_GAIN, 64'(int'($urandom_range(32'd524288)) - 262144));
                write_reg(REG_PHYSICAL_MIN, {{24{r[31]}}, r, 8'h00});
            end

            length = $urandom_range(120, 40);
            repeat (length) begin
                case ($urandom_range(15))
                    0:       b = 8'h00;
                    1:       b = 8'hFF;
                    default: b = 8'($urandom_range(255));
                endcase
                send_byte(b);
            end
            random_phases++;
        end
    endtask

    task automatic test_final_record();
        settle();
        send_idle_pct = 21;
        stall_pct     = 21;
        write_reg(REG_RECORD_WORDS, 64'd1);
        write_reg(REG_SKIP_WORDS, 64'd0);
        write_reg(REG_TAKE_WORDS, 64'd1);
        write_reg(REG_RECORD_COUNT, 64'hFF_FFFF);
        // align to a word and record boundary
        while (phase_q != 0 || word_pos_q != 0)
            send_byte(8'($urandom_range(255)));
        settle();
        write_reg(REG_RECORD_WORDS, 64'd2);
        write_reg(REG_SKIP_WORDS, 64'd1);
        write_reg(REG_TAKE_WORDS, 64'd4);
        write_reg(REG_RECORD_COUNT, 64'(rec_idx_q) + 64'd1);
        while (!done_q)
            send_byte(8'($urandom_range(255)));
        // bytes past the end of the decode
        repeat (4) send_byte(8'($urandom_range(255)));
    endtask

    initial begin : run
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_data_byte = '0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_register_reset();
        test_edf_word_extremes();
        test_saturation();
        test_width_switch();
        test_zero_record_count();
        test_zero_take();
        test_zero_record_words();
        test_window_past_record_end();
        test_random_streams();
        test_final_record();
        settle();

        $display("Decoded %0d of %0d bytes over %0d random setups, %0d register writes.",
                 bytes_decoded, bytes_sent, random_phases, config_writes);
        $display("Checked %0d samples: %0d saturated, %0d marked last.",
                 samples_checked, clipped_seen, last_seen);
        if (error_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/edfbdf_pkg.sv
rtl/edfbdf_front.sv
rtl/edfbdf_queue.sv
rtl/edfbdf_back.sv
rtl/edf_bdf_channel_sample_decoder_top.sv
tb/edf_bdf_channel_sample_decoder_top_tb.sv
